// ===== rtl/tcsb_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tcsb_pkg
// Shared sizes, request codes and character constants for the text console
// scroll buffer.
// ----------------------------------------------------------------------------
package tcsb_pkg;

    localparam int ROWS   = 26;
    localparam int COLS   = 40;
    localparam int CELLS  = ROWS * COLS;

    localparam int ROW_W  = 5;
    localparam int COL_W  = 6;
    localparam int DATA_W = 8;
    localparam int ADDR_W = $clog2(CELLS);

    typedef logic [ROW_W-1:0]  t_row;
    typedef logic [COL_W-1:0]  t_col;
    typedef logic [DATA_W-1:0] t_byte;
    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [1:0]        t_req;

    localparam t_req REQ_PUT   = 2'd0;
    localparam t_req REQ_CLEAR = 2'd1;
    localparam t_req REQ_READ  = 2'd2;

    localparam t_byte CH_LF    = 8'd10;
    localparam t_byte CH_CR    = 8'd13;
    localparam t_byte CH_SPACE = 8'd32;
    localparam t_byte CH_MAX   = 8'd127;

    localparam t_row LAST_ROW  = t_row'(ROWS - 1);
    localparam t_col FULL_COL  = t_col'(COLS);

endpackage

`default_nettype wire

// ===== rtl/tcsb_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tcsb_ram
// Generic simple dual-port RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module tcsb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/tcsb_addr.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tcsb_addr
// Map a logical row and column to a linear cell address over the circular
// row store.
// ----------------------------------------------------------------------------
module tcsb_addr (
    input  wire tcsb_pkg::t_row i_top,
    input  wire tcsb_pkg::t_row i_row,
    input  wire tcsb_pkg::t_col i_col,
    output tcsb_pkg::t_addr     o_addr
);
    import tcsb_pkg::*;

    logic [ROW_W:0] sum;
    logic [ROW_W:0] wrapped;
    t_row           phys;

    always_comb begin
        sum     = {1'b0, i_top} + {1'b0, i_row};
        wrapped = (sum >= (ROW_W+1)'(ROWS)) ? sum - (ROW_W+1)'(ROWS) : sum;
        phys    = wrapped[ROW_W-1:0];
        o_addr  = t_addr'(phys) * t_addr'(COLS) + t_addr'(i_col);
    end

endmodule

`default_nettype wire

// ===== rtl/text_console_scroll_buffer_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// text_console_scroll_buffer_core
// Character cell console store with cursor, newline and row scrolling.
// Carriage return, newline without scroll, unused codes and out-of-range reads
//   are answered straight from idle; a plain put passes a write state, a read
//   one memory read; a scroll first blanks a row of COLS cells; clear blanks all.
// One item at a time: busy is high until the strobe, never if answered from idle.
// After reset every cell of the store is blanked with busy high.
// The result strobe lasts one cycle; the receiver cannot stall.
// ----------------------------------------------------------------------------
module text_console_scroll_buffer_core (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            start,
    output logic                 busy,
    input  wire tcsb_pkg::t_req  i_req_type,
    input  wire tcsb_pkg::t_byte i_char_in,
    input  wire tcsb_pkg::t_row  i_read_row,
    input  wire tcsb_pkg::t_col  i_read_col,
    output logic                 o_valid,
    output tcsb_pkg::t_byte      o_read_data,
    output tcsb_pkg::t_row       o_cursor_row,
    output tcsb_pkg::t_col       o_cursor_col,
    output logic                 o_scrolled,
    output logic                 o_line_done
);
    import tcsb_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SWEEP = 2'd1;
    localparam logic [1:0] ST_WRITE = 2'd2;
    localparam logic [1:0] ST_READ  = 2'd3;

    logic [1:0] r_state, n_state;
    t_row       r_row, n_row;
    t_col       r_col, n_col;
    t_row       r_top, n_top;
    t_addr      r_sweep_addr, n_sweep_addr;
    t_addr      r_sweep_left, n_sweep_left;
    t_addr      r_wr_addr, n_wr_addr;
    t_byte      r_wr_data, n_wr_data;
    logic       r_wr_pend, n_wr_pend;
    logic       r_resp_pend, n_resp_pend;
    logic       r_strobe, n_strobe;
    t_byte      r_rdata, n_rdata;
    logic       r_scrolled, n_scrolled;
    logic       r_done, n_done;

    logic  accept;
    logic  is_lf;
    logic  is_cr;
    logic  newline;
    logic  scroll;
    t_row  put_row;
    t_col  put_col;
    t_byte put_val;
    logic  rd_in_range;
    t_row  a_top;
    t_row  a_row;
    t_col  a_col;
    t_addr a_addr;
    logic  mem_we;
    t_addr mem_waddr;
    t_byte mem_wdata;
    t_byte mem_rdata;

    assign accept      = start && !busy;
    assign is_lf       = (i_char_in == CH_LF);
    assign is_cr       = (i_char_in == CH_CR);
    assign newline     = is_lf || (r_col >= FULL_COL);
    assign scroll      = newline && (r_row >= LAST_ROW);
    assign put_row     = (newline && !scroll) ? r_row + t_row'(1) : r_row;
    assign put_col     = newline ? t_col'(0) : r_col;
    assign put_val     = (i_char_in < CH_SPACE || i_char_in > CH_MAX) ? CH_SPACE : i_char_in;
    assign rd_in_range = (i_read_row < t_row'(ROWS)) && (i_read_col < t_col'(COLS));

    always_comb begin
        a_top = r_top;
        a_row = i_read_row;
        a_col = i_read_col;
        if (i_req_type == REQ_PUT) begin
            a_row = scroll ? t_row'(0) : put_row;
            a_col = put_col;
        end
    end

    tcsb_addr u_addr (
        .i_top  (a_top),
        .i_row  (a_row),
        .i_col  (a_col),
        .o_addr (a_addr)
    );

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_wr_addr;
        mem_wdata = r_wr_data;
        unique case (r_state)
            ST_SWEEP: begin
                mem_we    = 1'b1;
                mem_waddr = r_sweep_addr;
                mem_wdata = '0;
            end
            ST_WRITE: begin
                mem_we = 1'b1;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    tcsb_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CELLS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (a_addr),
        .o_rdata (mem_rdata)
    );

    always_comb begin
        n_state      = r_state;
        n_row        = r_row;
        n_col        = r_col;
        n_top        = r_top;
        n_sweep_addr = r_sweep_addr;
        n_sweep_left = r_sweep_left;
        n_wr_addr    = r_wr_addr;
        n_wr_data    = r_wr_data;
        n_wr_pend    = r_wr_pend;
        n_resp_pend  = r_resp_pend;
        n_strobe     = 1'b0;
        n_rdata      = r_rdata;
        n_scrolled   = r_scrolled;
        n_done       = r_done;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_rdata    = '0;
                    n_scrolled = 1'b0;
                    n_done     = 1'b0;
                    n_strobe   = 1'b1;
                    unique case (i_req_type)
                        REQ_PUT: begin
                            if (!is_cr) begin
                                n_row      = put_row;
                                n_col      = is_lf ? t_col'(0) : put_col + t_col'(1);
                                n_done     = is_lf;
                                n_scrolled = scroll;
                                n_wr_addr  = a_addr;
                                n_wr_data  = put_val;
                                if (scroll) begin
                                    n_top        = (r_top >= LAST_ROW) ? t_row'(0)
                                                                       : r_top + t_row'(1);
                                    n_sweep_addr = a_addr;
                                    n_sweep_left = t_addr'(COLS - 1);
                                    n_wr_pend    = !is_lf;
                                    n_resp_pend  = 1'b1;
                                    n_strobe     = 1'b0;
                                    n_state      = ST_SWEEP;
                                end else if (!is_lf) begin
                                    n_strobe = 1'b0;
                                    n_state  = ST_WRITE;
                                end
                            end
                        end
                        REQ_CLEAR: begin
                            n_row        = '0;
                            n_col        = '0;
                            n_top        = '0;
                            n_sweep_addr = '0;
                            n_sweep_left = t_addr'(CELLS - 1);
                            n_wr_pend    = 1'b0;
                            n_resp_pend  = 1'b1;
                            n_strobe     = 1'b0;
                            n_state      = ST_SWEEP;
                        end
                        REQ_READ: begin
                            if (rd_in_range) begin
                                n_strobe = 1'b0;
                                n_state  = ST_READ;
                            end
                        end
                        default: begin
                            n_strobe = 1'b1;
                        end
                    endcase
                end
            end
            ST_SWEEP: begin
                if (r_sweep_left == '0) begin
                    if (r_wr_pend) begin
                        n_state = ST_WRITE;
                    end else begin
                        n_strobe = r_resp_pend;
                        n_state  = ST_IDLE;
                    end
                    n_wr_pend = 1'b0;
                end else begin
                    n_sweep_addr = r_sweep_addr + t_addr'(1);
                    n_sweep_left = r_sweep_left - t_addr'(1);
                end
            end
            ST_WRITE: begin
                n_strobe = 1'b1;
                n_state  = ST_IDLE;
            end
            ST_READ: begin
                n_rdata  = mem_rdata;
                n_strobe = 1'b1;
                n_state  = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_SWEEP;
            r_row        <= '0;
            r_col        <= '0;
            r_top        <= '0;
            r_sweep_addr <= '0;
            r_sweep_left <= t_addr'(CELLS - 1);
            r_wr_pend    <= 1'b0;
            r_resp_pend  <= 1'b0;
            r_strobe     <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_row        <= n_row;
            r_col        <= n_col;
            r_top        <= n_top;
            r_sweep_addr <= n_sweep_addr;
            r_sweep_left <= n_sweep_left;
            r_wr_pend    <= n_wr_pend;
            r_resp_pend  <= n_resp_pend;
            r_strobe     <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_wr_addr  <= n_wr_addr;
        r_wr_data  <= n_wr_data;
        r_rdata    <= n_rdata;
        r_scrolled <= n_scrolled;
        r_done     <= n_done;
    end

    assign busy         = (r_state != ST_IDLE);
    assign o_valid      = r_strobe;
    assign o_read_data  = r_rdata;
    assign o_cursor_row = r_row;
    assign o_cursor_col = r_col;
    assign o_scrolled   = r_scrolled;
    assign o_line_done  = r_done;

    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while busy");

    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (busy || o_valid))
        else $error("accepted item neither worked on nor answered");

    a_scroll_bottom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_scrolled) |-> (o_cursor_row == LAST_ROW))
        else $error("scroll reported off the bottom row");

    a_newline_home: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_line_done) |-> (o_cursor_col == '0))
        else $error("newline did not home the column");

endmodule

`default_nettype wire

// ===== verif/text_console_scroll_buffer_core_tb.sv =====
// ----------------------------------------------------------------------------
// text_console_scroll_buffer_core_tb
// Self-checking bench for the console store: drives put, clear, read and
// unused requests through the start/busy handshake with random gaps, tracks
// the cursor, the scroll position and every cell in a shadow copy, and checks
// each result strobe against the oldest outstanding item.
// ----------------------------------------------------------------------------
module text_console_scroll_buffer_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tcsb_pkg::*;

    localparam t_req REQ_UNUSED  = 2'd3;
    localparam int   ITEM_COUNT  = 1050;
    localparam int   STALL_LIMIT = 4000;

    typedef struct packed {
        t_byte data;
        t_row  row;
        t_col  col;
        logic  scrolled;
        logic  line_done;
    } t_console_result;

    class t_console_tracker;
        t_byte           cells[ROWS][COLS];
        int              top_row;
        t_row            cur_row;
        t_col            cur_col;
        t_console_result pending_results[$];
        int              mismatches;
        int              results_seen;

        function new();
            mismatches   = 0;
            results_seen = 0;
            wipe();
        endfunction

        function void wipe();
            foreach (cells[r, c]) cells[r][c] = '0;
            top_row = 0;
            cur_row = '0;
            cur_col = '0;
        endfunction

        function void scroll_up();
            for (int c = 0; c < COLS; c++) cells[top_row][c] = '0;
            top_row = (top_row + 1) % ROWS;
        endfunction

        function void apply_request(t_req req, t_byte ch, t_row rr, t_col rc);
            t_console_result res;
            bit              stop;
            res  = '0;
            stop = 1'b0;
            case (req)
                REQ_PUT: begin
                    if (ch != CH_CR) begin
                        if (ch == CH_LF || cur_col >= FULL_COL) begin
                            if (cur_row >= LAST_ROW) begin
                                scroll_up();
                                res.scrolled = 1'b1;
                            end else begin
                                cur_row++;
                            end
                            cur_col = '0;
                            if (ch == CH_LF) begin
                                res.line_done = 1'b1;
                                stop = 1'b1;
                            end
                        end
                        if (!stop) begin
                            cells[(top_row + cur_row) % ROWS][cur_col] =
                                (ch < CH_SPACE || ch > CH_MAX) ? CH_SPACE : ch;
                            cur_col++;
                        end
                    end
                end
                REQ_CLEAR: wipe();
                REQ_READ: begin
                    if (rr < ROWS && rc < COLS) res.data = cells[(top_row + rr) % ROWS][rc];
                end
                default: ;
            endcase
            res.row = cur_row;
            res.col = cur_col;
            pending_results.push_back(res);
        endfunction

        task report_mismatch(string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            mismatches++;
        endtask

        task match_result(t_console_result got);
            t_console_result want;
            results_seen++;
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("result %0d arrived with no item outstanding",
                                          results_seen));
                return;
            end
            want = pending_results.pop_front();
            if (got !== want) begin
                report_mismatch($sformatf(
                    "result %0d: want %02h %0d %0d %b %b, got %02h %0d %0d %b %b",
                    results_seen, want.data, want.row, want.col, want.scrolled, want.line_done,
                    got.data, got.row, got.col, got.scrolled, got.line_done));
            end
        endtask
    endclass

    logic  i_clk = 1'b0;
    logic  i_rst_n;
    logic  start;
    logic  busy;
    t_req  req_type;
    t_byte char_in;
    t_row  read_row;
    t_col  read_col;
    logic  valid;
    t_byte read_data;
    t_row  cursor_row;
    t_col  cursor_col;
    logic  scrolled;
    logic  line_done;

    t_console_tracker tracker = new();
    int               items_sent = 0;
    int               idle_cycles = 0;
    bit               no_gap = 1'b0;

    text_console_scroll_buffer_core uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_req_type   (req_type),
        .i_char_in    (char_in),
        .i_read_row   (read_row),
        .i_read_col   (read_col),
        .o_valid      (valid),
        .o_read_data  (read_data),
        .o_cursor_row (cursor_row),
        .o_cursor_col (cursor_col),
        .o_scrolled   (scrolled),
        .o_line_done  (line_done)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        t_console_result seen;
        bit              took;
        seen = {read_data, cursor_row, cursor_col, scrolled, line_done};
        took = i_rst_n && start && (busy === 1'b0);
        if (i_rst_n && valid === 1'b1) tracker.match_result(seen);
        if (took) tracker.apply_request(req_type, char_in, read_row, read_col);
        if (took || (i_rst_n && valid === 1'b1)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_request(t_req req, t_byte ch, t_row rr, t_col rc);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start    <= 1'b1;
        req_type <= req;
        char_in  <= ch;
        read_row <= rr;
        read_col <= rc;
        do @(posedge i_clk); while (busy !== 1'b0);
        items_sent++;
    endtask

    task automatic drain_results();
        start <= 1'b0;
        do @(posedge i_clk); while (tracker.pending_results.size() != 0);
    endtask

    initial begin
        int    kind;
        int    len;
        t_byte ch;
        t_row  rr;
        t_col  rc;
        i_rst_n  = 1'b0;
        start    = 1'b0;
        req_type = REQ_PUT;
        char_in  = '0;
        read_row = '0;
        read_col = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_request(REQ_READ, 8'h00, 5'd0, 6'd0);
        send_request(REQ_PUT, 8'h41, 5'd0, 6'd0);
        send_request(REQ_PUT, 8'h00, 5'd31, 6'd63);
        send_request(REQ_PUT, 8'hFF, 5'd0, 6'd0);
        send_request(REQ_PUT, CH_MAX, 5'd0, 6'd0);
        send_request(REQ_PUT, 8'd31, 5'd0, 6'd0);
        send_request(REQ_PUT, 8'h80, 5'd0, 6'd0);
        send_request(REQ_PUT, CH_CR, 5'd0, 6'd0);
        send_request(REQ_PUT, CH_SPACE, 5'd0, 6'd0);
        for (int c = 0; c < 4; c++) send_request(REQ_READ, 8'h00, 5'd0, t_col'(c));
        send_request(REQ_PUT, CH_LF, 5'd0, 6'd0);
        send_request(REQ_READ, 8'h00, LAST_ROW, t_col'(COLS - 1));
        send_request(REQ_READ, 8'h00, t_row'(ROWS), 6'd0);
        send_request(REQ_READ, 8'hFF, 5'd31, 6'd63);
        send_request(REQ_READ, 8'h00, 5'd0, FULL_COL);
        send_request(REQ_READ, 8'h00, 5'd0, 6'd63);
        send_request(REQ_UNUSED, 8'hFF, 5'd31, 6'd63);
        send_request(REQ_CLEAR, 8'h00, 5'd0, 6'd0);
        send_request(REQ_READ, 8'h00, 5'd0, 6'd0);
        send_request(REQ_PUT, 8'h7E, 5'd0, 6'd0);
        drain_results();

        while (items_sent < ITEM_COUNT) begin
            kind   = $urandom_range(0, 15);
            no_gap = ($urandom_range(0, 3) == 0);
            if (kind < 9) begin
                len = $urandom_range(0, 48);
                repeat (len) begin
                    ch = ($urandom_range(0, 11) == 0) ? t_byte'($urandom)
                                                      : t_byte'($urandom_range(32, 126));
                    send_request(REQ_PUT, ch, t_row'($urandom), t_col'($urandom));
                end
                if ($urandom_range(0, 3) != 0)
                    send_request(REQ_PUT, CH_LF, t_row'($urandom), t_col'($urandom));
            end else if (kind < 13) begin
                repeat ($urandom_range(1, 6)) begin
                    if ($urandom_range(0, 7) == 0) begin
                        rr = t_row'($urandom);
                        rc = t_col'($urandom);
                    end else begin
                        rr = t_row'($urandom_range(0, ROWS - 1));
                        rc = t_col'($urandom_range(0, COLS - 1));
                    end
                    send_request(REQ_READ, t_byte'($urandom), rr, rc);
                end
            end else if (kind < 15) begin
                case ($urandom_range(0, 2))
                    0: send_request(REQ_PUT, CH_CR, t_row'($urandom), t_col'($urandom));
                    1: send_request(REQ_UNUSED, t_byte'($urandom), t_row'($urandom),
                                    t_col'($urandom));
                    default: send_request(REQ_PUT, t_byte'($urandom), t_row'($urandom),
                                          t_col'($urandom));
                endcase
            end else if ($urandom_range(0, 5) == 0) begin
                send_request(REQ_CLEAR, t_byte'($urandom), t_row'($urandom), t_col'($urandom));
            end else begin
                drain_results();
            end
        end

        drain_results();
        repeat (20) @(posedge i_clk);
        if (tracker.pending_results.size() != 0)
            tracker.report_mismatch($sformatf("%0d results never arrived",
                                              tracker.pending_results.size()));
        if (tracker.mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
